>>> sv/fle_pkg.sv
// shared types and constants for the free list entry allocator
// no dependencies
`timescale 1ns / 1ps

package fle_pkg;

   localparam int DEPTH = 1024;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = IDX_W + 1;
   // memory word: allocated mark on top, free list link below
   localparam int WORD_W = IDX_W + 1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_CAPACITY = 1'b0;
   localparam logic [CNT_W-1:0] CAPACITY_RESET = CNT_W'(1024);

   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE  = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
   localparam logic [1:0] STATUS_BAD       = 2'd2;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [IDX_W-1:0] entry_index;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] granted_index;
      logic [1:0]       status;
      logic             is_allocated;
      logic [CNT_W-1:0] live_entries;
   } rsp_type;

   // one write port and one registered read port toward the entry memory
   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [WORD_W-1:0] wr_data;
      logic              rd_en;
      logic [IDX_W-1:0]  rd_addr;
   } mem_req_type;

endpackage

>>> sv/fle_ram.sv
// generic single clock ram, one write port and one read port with registered data
// no dependencies
`timescale 1ns / 1ps

module fle_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/fle_csr.sv
// capacity register behind an apb style port
// depends on fle_pkg
`timescale 1ns / 1ps

module fle_csr
   import fle_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [CNT_W-1:0]      capacity
);

   logic [CNT_W-1:0] capacity_ff;
   logic [CNT_W-1:0] capacity_in;
   logic             wr_hit;

   // byte offset within the word is ignored
   assign wr_hit = psel && penable && pwrite && (paddr[2] == CSR_IDX_CAPACITY);

   always_comb begin
      capacity_in = capacity_ff;
      if (wr_hit) begin
         capacity_in = pwdata[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == CSR_IDX_CAPACITY) begin
         prdata = {{(CSR_DATA_W-CNT_W){1'b0}}, capacity_ff};
      end
   end

   assign pready   = 1'b1;
   assign capacity = capacity_ff;

endmodule

>>> sv/fle_ctrl.sv
// sequencer of the allocator: clearing sweep, read of the entry word, update and result
// depends on fle_pkg; drives the entry memory through mem_req_type
`timescale 1ns / 1ps

module fle_ctrl
   import fle_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [CNT_W-1:0]  capacity,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   output mem_req_type       mem_req,
   input  logic [WORD_W-1:0] mem_rd_data
);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } state_type;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic             empty_ff, empty_in;
   logic [CNT_W-1:0] bump_ff, bump_in;
   logic [CNT_W-1:0] live_ff, live_in;
   req_type          op_ff, op_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [CNT_W-1:0] bump_limit;
   logic [CNT_W-1:0] live_inc;
   logic             rd_mark;
   logic [IDX_W-1:0] rd_link;

   assign bump_limit = (capacity < DEPTH_CNT) ? capacity : DEPTH_CNT;
   assign live_inc   = live_ff + CNT_W'(1);
   assign rd_mark    = mem_rd_data[WORD_W-1];
   assign rd_link    = mem_rd_data[IDX_W-1:0];

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      head_in      = head_ff;
      empty_in     = empty_ff;
      bump_in      = bump_ff;
      live_in      = live_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      mem_req      = '0;
      mem_req.wr_addr = clr_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = clr_ff;
            mem_req.wr_data = '0;
            clr_in = clr_ff + IDX_W'(1);
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in         = req_data;
               mem_req.rd_en = 1'b1;
               if (req_data.cmd == CMD_ALLOC) begin
                  mem_req.rd_addr = empty_ff ? bump_ff[IDX_W-1:0] : head_ff;
               end else begin
                  mem_req.rd_addr = req_data.entry_index;
               end
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // the read word of the addressed entry is ready here
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in = '0;
               rsp_in.status = STATUS_OK;
               if (op_ff.cmd == CMD_ALLOC) begin
                  if (!empty_ff) begin
                     rsp_in.granted_index = head_ff;
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = head_ff;
                     mem_req.wr_data = {1'b1, rd_link};
                     head_in  = rd_link;
                     live_in  = live_inc;
                     empty_in = (live_inc >= bump_ff);
                  end else if (bump_ff < bump_limit) begin
                     rsp_in.granted_index = bump_ff[IDX_W-1:0];
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = bump_ff[IDX_W-1:0];
                     mem_req.wr_data = {1'b1, rd_link};
                     bump_in = bump_ff + CNT_W'(1);
                     live_in = live_inc;
                  end else begin
                     rsp_in.status = STATUS_EXHAUSTED;
                  end
               end else if (op_ff.cmd == CMD_FREE) begin
                  if (!rd_mark) begin
                     rsp_in.status = STATUS_BAD;
                  end else begin
                     // push onto the list, link to the old head
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = op_ff.entry_index;
                     mem_req.wr_data = {1'b0, head_ff};
                     head_in  = op_ff.entry_index;
                     empty_in = 1'b0;
                     if (live_ff != '0) begin
                        live_in = live_ff - CNT_W'(1);
                     end
                  end
               end else if (op_ff.cmd == CMD_QUERY) begin
                  rsp_in.is_allocated = rd_mark;
               end
               rsp_in.live_entries = live_in;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         head_ff      <= '0;
         empty_ff     <= 1'b1;
         bump_ff      <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         empty_ff     <= empty_in;
         bump_ff      <= bump_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      rsp_ff <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> sv/free_list_entry_allocator_core.sv
// Entry allocator for a table of 1024 entries. Each entry has one memory word that holds
// its allocated mark and its free list link; allocate pops the free list head or takes
// the next index from a bump pointer, free pushes, query reads the mark. Every item
// first reads its entry word from the single memory, whose read data is registered,
// and then updates it and loads the result register, so the next pop sees the
// new head. A result that waits on rsp_stall holds the next item in the update step.
// After reset the block clears all allocated marks, one entry a cycle, over all 1024
// entries; req_stall is high during that sweep, and capacity writes are taken as ever.
// depends on fle_pkg, fle_ram, fle_csr, fle_ctrl
`timescale 1ns / 1ps

module free_list_entry_allocator_core
   import fle_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [CNT_W-1:0]  capacity;
   mem_req_type       mem_req;
   logic [WORD_W-1:0] mem_rd_data;

   fle_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .capacity (capacity)
   );

   fle_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .capacity    (capacity),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data)
   );

   fle_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule
